@@ hdl/clp_pkg.sv @@
// Package with the shared types, constants and the transfer packing function of the text pager.
`timescale 1ns / 1ps

package clp_pkg;

   localparam int LINE_LENGTH = 16;
   localparam int BANK_DEPTH  = 128;

   localparam int BANK_AW  = $clog2(BANK_DEPTH);
   localparam int STORE_AW = BANK_AW + 1;
   localparam int CHAR_W   = 7;
   localparam int LEN_W    = 7;

   localparam logic [1:0] KIND_CHAR   = 2'd0;
   localparam logic [1:0] KIND_COMMIT = 2'd1;
   localparam logic [1:0] KIND_TICK   = 2'd2;

   localparam logic [7:0] EXP_BACKLIGHT = 8'h08;
   localparam logic [7:0] EXP_ENABLE    = 8'h04;
   localparam logic [7:0] NIBBLE_MASK   = 8'hF0;

   localparam logic [7:0] CMD_CLEAR = 8'h01;
   localparam logic [7:0] CMD_LINE0 = 8'h80;
   localparam logic [7:0] CMD_LINE1 = 8'hC0;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_FIRST = 8'h20;
   localparam logic [7:0] CHAR_LAST  = 8'h7E;

   localparam logic [LEN_W-1:0] RAW_LIMIT = 7'd127;
   localparam logic [15:0] PERIOD_RESET = 16'd8000;

   localparam int INIT_COUNT = 6;
   localparam logic [7:0] INIT_SEQ [INIT_COUNT] = '{8'h33, 8'h32, 8'h28, 8'h0C, 8'h06, 8'h01};

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] char_code;
   } req_type;

   typedef struct packed {
      logic [7:0] xfer_byte0;
      logic [7:0] xfer_byte1;
      logic [7:0] xfer_byte2;
      logic [7:0] xfer_byte3;
      logic [7:0] xfer_byte4;
      logic [7:0] xfer_byte5;
      logic       reg_select;
      logic       wait_power_up;
      logic       wait_after_clear;
      logic       last;
   } rsp_type;

   // Splits one display byte into the six expander bytes of a 4-bit write.
   function automatic rsp_type clp_pack(input logic [7:0] b, input logic rs, input logic pwr,
                                        input logic clr, input logic lst);
      logic [7:0] hi;
      logic [7:0] lo;
      rsp_type    r;
      hi = (b & NIBBLE_MASK) | EXP_BACKLIGHT | {7'b0, rs};
      lo = {b[3:0], 4'b0} | EXP_BACKLIGHT | {7'b0, rs};
      r.xfer_byte0       = hi;
      r.xfer_byte1       = hi | EXP_ENABLE;
      r.xfer_byte2       = hi;
      r.xfer_byte3       = lo;
      r.xfer_byte4       = lo | EXP_ENABLE;
      r.xfer_byte5       = lo;
      r.reg_select       = rs;
      r.wait_power_up    = pwr;
      r.wait_after_clear = clr;
      r.last             = lst;
      return r;
   endfunction

endpackage

@@ hdl/clp_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module clp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/char_lcd_text_pager.sv @@
// Top level of the character display text pager: text staging, bank swap and transfer sequencer.
`timescale 1ns / 1ps

// Items are taken while busy is low. A text character gives no transfer, and an idle tick
// gives none unless it ends the toggle period. A commit keeps busy high while the sequencer
// walks the init commands and both lines, and a tick that ends the period of a page longer
// than two lines keeps it high for a screen toggle of both lines; in both it gives one
// transfer per cycle and reads one character per cycle from the text store RAM. Each
// transfer is shown on rsp_data for one cycle with rsp_strobe high and must be taken then;
// the block never waits for the receiver. The text store needs no clearing pass after reset.
module char_lcd_text_pager (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  clp_pkg::req_type req_data,
   output logic             rsp_strobe,
   output clp_pkg::rsp_type rsp_data,
   input  logic             csr_wen,
   input  logic [15:0]      csr_wdata
);

   import clp_pkg::*;

   localparam int COL_W = $clog2(LINE_LENGTH);
   localparam int IDX_W = $clog2(4 * LINE_LENGTH);
   localparam int CMP_W = ((IDX_W > LEN_W) ? IDX_W : LEN_W) + 1;
   localparam int LIM_W = $clog2(BANK_DEPTH + 1) + 1;
   localparam logic [LEN_W-1:0] TWO_LINES = LEN_W'(2 * LINE_LENGTH);
   localparam logic [COL_W-1:0] COL_LAST  = COL_W'(LINE_LENGTH - 1);
   localparam logic [2:0]       INIT_LAST = 3'(INIT_COUNT - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_INIT,
      ST_ADDR,
      ST_CHARS
   } state_type;

   state_type         state_ff, state_in;
   logic [2:0]        init_ff, init_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic              line_ff, line_in;
   logic              bank_ff, bank_in;
   logic [LEN_W-1:0]  act_len_ff, act_len_in;
   logic [LEN_W-1:0]  stg_len_ff, stg_len_in;
   logic [LEN_W-1:0]  raw_ff, raw_in;
   logic              first_ff, first_in;
   logic [15:0]       cd_ff, cd_in;
   logic              armed_ff, armed_in;
   logic [15:0]       period_ff, period_in;
   logic              ok_ff, ok_in;
   logic              rsp_strobe_ff, rsp_strobe_in;
   rsp_type           rsp_ff, rsp_in;

   logic                wr_en;
   logic [STORE_AW-1:0] wr_addr;
   logic [STORE_AW-1:0] rd_addr;
   logic [CHAR_W-1:0]   rd_data;
   logic [COL_W:0]      rd_col;
   logic [IDX_W-1:0]    rd_idx;
   logic [15:0]         period_eff;
   logic [15:0]         cd_dec;
   logic                printable;
   logic [7:0]          char_byte;

   clp_ram #(
      .WIDTH(CHAR_W),
      .DEPTH(2 ** STORE_AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_data.char_code[CHAR_W-1:0]),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // The read for a character is issued in the cycle before it is sent: during the line address
   // command for the first column, and during each character for the next one.
   assign rd_col = (state_ff == ST_ADDR) ? '0 : ({1'b0, col_ff} + 1'b1);
   assign rd_idx = IDX_W'(first_ff ? 0 : 2 * LINE_LENGTH)
                 + IDX_W'(line_ff ? LINE_LENGTH : 0)
                 + IDX_W'(rd_col);
   assign rd_addr = {bank_ff, BANK_AW'(rd_idx)};
   assign wr_addr = {~bank_ff, BANK_AW'(stg_len_ff)};

   assign period_eff = (period_ff == 16'd0) ? 16'd1 : period_ff;
   assign cd_dec     = (cd_ff == 16'd0) ? 16'd0 : (cd_ff - 16'd1);
   assign printable  = (req_data.char_code >= CHAR_FIRST) && (req_data.char_code <= CHAR_LAST);
   assign char_byte  = ok_ff ? {1'b0, rd_data} : CHAR_SPACE;

   always_comb begin
      state_in      = state_ff;
      init_in       = init_ff;
      col_in        = col_ff;
      line_in       = line_ff;
      bank_in       = bank_ff;
      act_len_in    = act_len_ff;
      stg_len_in    = stg_len_ff;
      raw_in        = raw_ff;
      first_in      = first_ff;
      cd_in         = cd_ff;
      armed_in      = armed_ff;
      period_in     = csr_wen ? csr_wdata : period_ff;
      ok_in         = CMP_W'(rd_idx) < CMP_W'(act_len_ff);
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      wr_en         = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               unique case (req_data.kind)
                  KIND_CHAR: begin
                     if (raw_ff < RAW_LIMIT) begin
                        raw_in = raw_ff + 1'b1;
                        if (printable && (LIM_W'(stg_len_ff) < LIM_W'(BANK_DEPTH))) begin
                           wr_en      = 1'b1;
                           stg_len_in = stg_len_ff + 1'b1;
                        end
                     end
                  end
                  KIND_COMMIT: begin
                     bank_in    = ~bank_ff;
                     act_len_in = stg_len_ff;
                     stg_len_in = '0;
                     raw_in     = '0;
                     first_in   = 1'b1;
                     if (stg_len_ff > TWO_LINES) begin
                        armed_in = 1'b1;
                        cd_in    = period_eff;
                     end else begin
                        armed_in = 1'b0;
                        cd_in    = 16'd0;
                     end
                     init_in  = '0;
                     state_in = ST_INIT;
                  end
                  KIND_TICK: begin
                     if (armed_ff) begin
                        cd_in = cd_dec;
                        if (cd_dec == 16'd0) begin
                           if (act_len_ff <= TWO_LINES) begin
                              armed_in = 1'b0;
                           end else begin
                              first_in = ~first_ff;
                              cd_in    = period_eff;
                              line_in  = 1'b0;
                              state_in = ST_ADDR;
                           end
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_INIT: begin
            rsp_strobe_in = 1'b1;
            rsp_in = clp_pack(INIT_SEQ[init_ff], 1'b0, init_ff == 3'd0,
                              INIT_SEQ[init_ff] == CMD_CLEAR, 1'b0);
            if (init_ff == INIT_LAST) begin
               line_in  = 1'b0;
               state_in = ST_ADDR;
            end else begin
               init_in = init_ff + 1'b1;
            end
         end
         ST_ADDR: begin
            rsp_strobe_in = 1'b1;
            rsp_in   = clp_pack(line_ff ? CMD_LINE1 : CMD_LINE0, 1'b0, 1'b0, 1'b0, 1'b0);
            col_in   = '0;
            state_in = ST_CHARS;
         end
         ST_CHARS: begin
            rsp_strobe_in = 1'b1;
            rsp_in = clp_pack(char_byte, 1'b1, 1'b0, 1'b0, line_ff && (col_ff == COL_LAST));
            if (col_ff == COL_LAST) begin
               if (line_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  line_in  = 1'b1;
                  state_in = ST_ADDR;
               end
            end else begin
               col_in = col_ff + 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         init_ff       <= '0;
         col_ff        <= '0;
         line_ff       <= 1'b0;
         bank_ff       <= 1'b0;
         act_len_ff    <= '0;
         stg_len_ff    <= '0;
         raw_ff        <= '0;
         first_ff      <= 1'b1;
         cd_ff         <= 16'd0;
         armed_ff      <= 1'b0;
         period_ff     <= PERIOD_RESET;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         init_ff       <= init_in;
         col_ff        <= col_in;
         line_ff       <= line_in;
         bank_ff       <= bank_in;
         act_len_ff    <= act_len_in;
         stg_len_ff    <= stg_len_in;
         raw_ff        <= raw_in;
         first_ff      <= first_in;
         cd_ff         <= cd_in;
         armed_ff      <= armed_in;
         period_ff     <= period_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      ok_ff  <= ok_in;
      rsp_ff <= rsp_in;
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

@@ bench/char_lcd_text_pager_tb.sv @@
// Self-checking testbench of the character display text pager, with its own transfer predictor.
`timescale 1ns / 1ps

module char_lcd_text_pager_tb;
   import clp_pkg::*;

   localparam logic [1:0] KIND_UNUSED  = 2'd3;
   localparam int         RANDOM_ITEMS = 40;
   localparam int         CYCLE_LIMIT  = 2_000_000;
   localparam int         SETTLE_CYCLES = 50;
   localparam int         MAX_PRINTED  = 40;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   req_type     req_data = '0;
   logic        rsp_strobe;
   rsp_type     rsp_data;
   logic        csr_wen = 1'b0;
   logic [15:0] csr_wdata = '0;

   // Predictor state, kept at the block's own widths.
   logic [CHAR_W-1:0] text_mem [2*BANK_DEPTH];
   logic              bank_sel = 1'b0;
   logic [LEN_W-1:0]  shown_len = '0;
   logic [LEN_W-1:0]  staged_len = '0;
   logic [LEN_W-1:0]  raw_cnt = '0;
   logic              first_half = 1'b1;
   logic [15:0]       ticks_left = '0;
   logic              timer_on = 1'b0;
   logic [15:0]       period_reg = PERIOD_RESET;

   rsp_type     expected_xfers [$];
   int unsigned mismatches = 0;
   int unsigned xfers_checked = 0;
   int unsigned items_taken = 0;
   int unsigned commits = 0;
   int unsigned screen_toggles = 0;
   int unsigned cycle_count = 0;
   int          idle_pct = 21;

   char_lcd_text_pager uut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   task automatic report_mismatch(input string msg);
      mismatches++;
      if (mismatches <= MAX_PRINTED) begin
         $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
      end
   endtask

   // ---------------------------------------------------------------- prediction

   task automatic push_xfer(input logic [7:0] b, input logic rs, input logic pwr,
                            input logic clr);
      rsp_type    x;
      logic [7:0] hi;
      logic [7:0] lo;
      hi = {b[7:4], 4'h0} | EXP_BACKLIGHT | {7'd0, rs};
      lo = {b[3:0], 4'h0} | EXP_BACKLIGHT | {7'd0, rs};
      x.xfer_byte0       = hi;
      x.xfer_byte1       = hi | EXP_ENABLE;
      x.xfer_byte2       = hi;
      x.xfer_byte3       = lo;
      x.xfer_byte4       = lo | EXP_ENABLE;
      x.xfer_byte5       = lo;
      x.reg_select       = rs;
      x.wait_power_up    = pwr;
      x.wait_after_clear = clr;
      x.last             = 1'b0;
      expected_xfers.push_back(x);
   endtask

   task automatic mark_last();
      rsp_type x;
      x = expected_xfers.pop_back();
      x.last = 1'b1;
      expected_xfers.push_back(x);
   endtask

   // Positions past the committed length read as spaces.
   function automatic logic [7:0] char_for(input int idx);
      if (idx < int'(shown_len) && idx < BANK_DEPTH) begin
         return {1'b0, text_mem[int'(bank_sel) * BANK_DEPTH + idx]};
      end
      return CHAR_SPACE;
   endfunction

   task automatic push_screen();
      int base;
      base = first_half ? 0 : 2 * LINE_LENGTH;
      push_xfer(CMD_LINE0, 1'b0, 1'b0, 1'b0);
      for (int i = 0; i < LINE_LENGTH; i++) push_xfer(char_for(base + i), 1'b1, 1'b0, 1'b0);
      push_xfer(CMD_LINE1, 1'b0, 1'b0, 1'b0);
      for (int i = 0; i < LINE_LENGTH; i++) begin
         push_xfer(char_for(base + LINE_LENGTH + i), 1'b1, 1'b0, 1'b0);
      end
   endtask

   task automatic rearm_timer();
      ticks_left = (period_reg == 16'd0) ? 16'd1 : period_reg;
      timer_on   = 1'b1;
   endtask

   task automatic predict_transfers(input req_type item);
      int slot;
      case (item.kind)
         KIND_CHAR: begin
            if (raw_cnt < RAW_LIMIT) begin
               raw_cnt++;
               if (item.char_code >= CHAR_FIRST && item.char_code <= CHAR_LAST &&
                   staged_len < BANK_DEPTH) begin
                  // The staging bank is the one not on display.
                  slot = (bank_sel ? 0 : BANK_DEPTH) + int'(staged_len);
                  text_mem[slot] = item.char_code[CHAR_W-1:0];
                  staged_len++;
               end
            end
         end
         KIND_COMMIT: begin
            bank_sel   = ~bank_sel;
            shown_len  = staged_len;
            staged_len = '0;
            raw_cnt    = '0;
            first_half = 1'b1;
            for (int i = 0; i < INIT_COUNT; i++) begin
               push_xfer(INIT_SEQ[i], 1'b0, i == 0, INIT_SEQ[i] == CMD_CLEAR);
            end
            push_screen();
            if (shown_len > 2 * LINE_LENGTH) begin
               rearm_timer();
            end else begin
               timer_on   = 1'b0;
               ticks_left = '0;
            end
            mark_last();
            commits++;
         end
         KIND_TICK: begin
            if (timer_on) begin
               if (ticks_left != 16'd0) ticks_left--;
               if (ticks_left == 16'd0) begin
                  if (shown_len <= 2 * LINE_LENGTH) begin
                     timer_on = 1'b0;
                  end else begin
                     first_half = ~first_half;
                     push_screen();
                     mark_last();
                     rearm_timer();
                     screen_toggles++;
                  end
               end
            end
         end
         default: begin
         end
      endcase
   endtask

   // ---------------------------------------------------------------- checking

   task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("transfer %0d: %s is %h, expected %h",
                                   xfers_checked, name, got, want));
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (expected_xfers.size() == 0) begin
            report_mismatch($sformatf("transfer with nothing expected: %h", rsp_data));
         end else begin
            want = expected_xfers.pop_front();
            check_field("xfer_byte0", rsp_data.xfer_byte0, want.xfer_byte0);
            check_field("xfer_byte1", rsp_data.xfer_byte1, want.xfer_byte1);
            check_field("xfer_byte2", rsp_data.xfer_byte2, want.xfer_byte2);
            check_field("xfer_byte3", rsp_data.xfer_byte3, want.xfer_byte3);
            check_field("xfer_byte4", rsp_data.xfer_byte4, want.xfer_byte4);
            check_field("xfer_byte5", rsp_data.xfer_byte5, want.xfer_byte5);
            check_field("reg_select", {7'd0, rsp_data.reg_select}, {7'd0, want.reg_select});
            check_field("wait_power_up", {7'd0, rsp_data.wait_power_up},
                        {7'd0, want.wait_power_up});
            check_field("wait_after_clear", {7'd0, rsp_data.wait_after_clear},
                        {7'd0, want.wait_after_clear});
            check_field("last", {7'd0, rsp_data.last}, {7'd0, want.last});
            xfers_checked++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d transfers outstanding.",
                  cycle_count, expected_xfers.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   // ---------------------------------------------------------------- stimulus

   // Leaves start high after the transfer so that back-to-back items need no extra step.
   task automatic send_item(input logic [1:0] kind, input logic [7:0] code);
      req_type item;
      item.kind      = kind;
      item.char_code = code;
      while ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (busy);
      predict_transfers(item);
      items_taken++;
   endtask

   task automatic wait_idle();
      start <= 1'b0;
      while (expected_xfers.size() != 0) @(posedge clock);
      // A character item may still be in flight when the last transfer has gone.
      repeat (8) @(posedge clock);
   endtask

   task automatic write_period(input logic [15:0] value);
      wait_idle();
      csr_wen   <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      period_reg = value;
      csr_wen   <= 1'b0;
   endtask

   function automatic logic [7:0] random_code(input int noise_pct);
      if ($urandom_range(0, 99) < noise_pct) return 8'($urandom_range(0, 255));
      return 8'($urandom_range(CHAR_FIRST, CHAR_LAST));
   endfunction

   task automatic send_text(input int count, input int noise_pct);
      repeat (count) send_item(KIND_CHAR, random_code(noise_pct));
   endtask

   task automatic send_ticks(input int count);
      repeat (count) send_item(KIND_TICK, 8'($urandom_range(0, 255)));
   endtask

   // Printable bounds, control and high codes, an unused kind, an idle tick and an empty commit.
   task automatic test_directed_basics();
      send_item(KIND_CHAR, 8'h00);
      send_item(KIND_CHAR, 8'hFF);
      send_item(KIND_CHAR, 8'h1F);
      send_item(KIND_CHAR, CHAR_FIRST);
      send_item(KIND_CHAR, CHAR_LAST);
      send_item(KIND_CHAR, 8'h7F);
      send_item(KIND_CHAR, 8'hAA);
      send_item(KIND_CHAR, 8'h55);
      send_item(KIND_CHAR, 8'h41);
      send_item(KIND_UNUSED, 8'hFF);
      send_item(KIND_TICK, 8'h00);
      send_item(KIND_COMMIT, 8'h00);
      send_item(KIND_TICK, 8'hFF);
      send_item(KIND_COMMIT, 8'hFF);
      send_item(KIND_UNUSED, 8'h00);
   endtask

   // Exactly two lines stays put; one character more alternates. A zero period acts as one.
   task automatic test_length_boundaries();
      write_period(16'd1);
      send_text(2 * LINE_LENGTH, 0);
      send_item(KIND_COMMIT, 8'h00);
      send_ticks(1);
      send_text(2 * LINE_LENGTH + 1, 0);
      send_item(KIND_COMMIT, 8'h00);
      send_ticks(2);
      write_period(16'd0);
      send_ticks(2);
   endtask

   // Characters beyond the raw limit are dropped even when printable. The text goes in
   // without any idling, under the widest period.
   task automatic test_raw_limit();
      write_period(16'hFFFF);
      idle_pct = 0;
      send_text(5, 100);
      send_text(int'(RAW_LIMIT) - 5 + 2, 0);
      idle_pct = 21;
      send_item(KIND_COMMIT, 8'h00);
      send_ticks(2);
   endtask

   // Mostly well-formed pages with random text, some unused kinds and missing commits.
   task automatic test_random_pages();
      int unsigned first_item;
      int          round;
      int          len;
      first_item = items_taken;
      round = 0;
      while (items_taken - first_item < RANDOM_ITEMS) begin
         if ($urandom_range(0, 2) == 0) write_period(16'($urandom_range(0, 4)));
         idle_pct = (round % 4 == 2) ? 0 : 21;
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: len = $urandom_range(0, 2 * LINE_LENGTH);
            default:          len = $urandom_range(2 * LINE_LENGTH + 1, 2 * LINE_LENGTH + 8);
         endcase
         repeat (len) begin
            if ($urandom_range(0, 19) == 0) send_item(KIND_UNUSED, 8'($urandom_range(0, 255)));
            else send_item(KIND_CHAR, random_code(15));
         end
         if ($urandom_range(0, 9) != 0) send_item(KIND_COMMIT, 8'($urandom_range(0, 255)));
         send_ticks($urandom_range(0, 3 * ((period_reg == 16'd0) ? 1 : int'(period_reg)) + 2));
         round++;
      end
      idle_pct = 21;
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_basics();
      test_length_boundaries();
      test_raw_limit();
      test_random_pages();
      start <= 1'b0;
      while (expected_xfers.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Run covered %0d items, %0d commits and %0d screen toggles; %0d transfers checked.",
               items_taken, commits, screen_toggles, xfers_checked);
      $display("Toggle periods: 0, 1, 65535 and random small ones; %0d mismatches.",
               mismatches);
      if (mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

@@ files.f @@
hdl/clp_pkg.sv
hdl/clp_ram.sv
hdl/char_lcd_text_pager.sv
bench/char_lcd_text_pager_tb.sv
